// ----- design/rfbf_pkg.sv -----
// package with constants, payload types and control types of the best-fit placer
`timescale 1ns / 1ps
package rfbf_pkg;

   localparam int HOSTS    = 64;
   localparam int DC_RANKS = 16;
   localparam int IDX_W    = (HOSTS > 1) ? $clog2(HOSTS) : 1;

   localparam int CMD_W   = 1;
   localparam int HIDX_W  = 6;
   localparam int CPU_W   = 32;
   localparam int MEM_W   = 24;
   localparam int RANK_W  = 4;
   localparam int TAG_W   = 16;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_PLACE = 1'b1;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [HIDX_W-1:0] host_index;
      logic [CPU_W-1:0]  host_free_cpu;
      logic [MEM_W-1:0]  host_free_mem;
      logic [RANK_W-1:0] host_rank;
      logic              host_active;
      logic [CPU_W-1:0]  vm_cpu;
      logic [MEM_W-1:0]  vm_mem;
      logic [TAG_W-1:0]  vm_tag;
   } req_type;

   typedef struct packed {
      logic              placed;
      logic [HIDX_W-1:0] chosen_host;
      logic [TAG_W-1:0]  result_tag;
   } rsp_type;

   typedef struct packed {
      logic              found;
      logic [RANK_W-1:0] rank;
      logic [CPU_W-1:0]  slack;
      logic [IDX_W-1:0]  index;
   } best_type;

   typedef struct packed {
      logic              load_en;
      logic              deduct_en;
      logic [IDX_W-1:0]  index;
      logic [CPU_W-1:0]  cpu;
      logic [MEM_W-1:0]  mem;
      logic [RANK_W-1:0] rank;
      logic              active;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   function automatic logic [RANK_W-1:0] sat_rank(input logic [RANK_W-1:0] r);
      logic [RANK_W-1:0] res;
      if (32'(r) > DC_RANKS - 1) begin
         res = RANK_W'(DC_RANKS - 1);
      end else begin
         res = r;
      end
      return res;
   endfunction

endpackage

// ----- design/rank_first_best_fit_placer_unit.sv -----
// top level of the rank-first best-fit host placer
`timescale 1ns / 1ps
// A load transfer writes one host entry in the same cycle it is accepted and
// gives no result; the next item can follow right away. A place transfer sends
// a search token down the row of 64 host cells, one cell per cycle, each cell
// keeping the better of the incoming candidate and its own host. After the
// last cell, the finish step deducts the demand from the chosen host and loads
// the result register, and it waits for as long as the result register stays
// stalled. The result register lets a new item be accepted while a finished
// result still waits.
module rank_first_best_fit_placer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rfbf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rfbf_pkg::rsp_type rsp_data
);

   rfbf_pkg::state_type state_ff, state_in;

   logic [rfbf_pkg::CPU_W-1:0] need_cpu_ff;
   logic [rfbf_pkg::MEM_W-1:0] need_mem_ff;
   logic [rfbf_pkg::TAG_W-1:0] tag_ff;
   logic                       start_ff;
   logic                       rsp_valid_ff;
   rfbf_pkg::rsp_type          rsp_ff;

   logic                       req_take;
   logic                       load_fire;
   logic                       place_fire;
   logic                       finish_fire;
   logic                       out_free;
   rfbf_pkg::cell_ctl_type     ctl;

   logic [rfbf_pkg::HOSTS:0]   step_chain;
   rfbf_pkg::best_type         best_chain [rfbf_pkg::HOSTS+1];
   logic [rfbf_pkg::HOSTS-1:0] active_vec;
   rfbf_pkg::best_type         last_best;
   logic                       last_step;

   assign req_stall  = (state_ff != rfbf_pkg::ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign last_best  = best_chain[rfbf_pkg::HOSTS];
   assign last_step  = step_chain[rfbf_pkg::HOSTS];
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rfbf_pkg::ST_IDLE: begin
            if (req_take && (req_data.cmd == rfbf_pkg::CMD_PLACE)) begin
               state_in = rfbf_pkg::ST_SCAN;
            end
         end
         rfbf_pkg::ST_SCAN: begin
            if (last_step) begin
               state_in = rfbf_pkg::ST_FINISH;
            end
         end
         rfbf_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = rfbf_pkg::ST_IDLE;
            end
         end
         default: state_in = rfbf_pkg::ST_IDLE;
      endcase
   end

   // outputs of the controller
   always_comb begin
      load_fire   = 1'b0;
      place_fire  = 1'b0;
      finish_fire = 1'b0;
      ctl         = '0;
      case (state_ff)
         rfbf_pkg::ST_IDLE: begin
            load_fire  = req_take && (req_data.cmd == rfbf_pkg::CMD_LOAD) &&
                         (32'(req_data.host_index) < rfbf_pkg::HOSTS);
            place_fire = req_take && (req_data.cmd == rfbf_pkg::CMD_PLACE);
            ctl.load_en = load_fire;
            ctl.index   = rfbf_pkg::IDX_W'(req_data.host_index);
            ctl.cpu     = req_data.host_free_cpu;
            ctl.mem     = req_data.host_free_mem;
            ctl.rank    = rfbf_pkg::sat_rank(req_data.host_rank);
            ctl.active  = req_data.host_active;
         end
         rfbf_pkg::ST_SCAN: begin
            ctl.cpu = need_cpu_ff;
            ctl.mem = need_mem_ff;
         end
         rfbf_pkg::ST_FINISH: begin
            finish_fire   = out_free;
            ctl.deduct_en = out_free && last_best.found;
            ctl.index     = last_best.index;
            ctl.cpu       = need_cpu_ff;
            ctl.mem       = need_mem_ff;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rfbf_pkg::ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= place_fire;
         if (finish_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (place_fire) begin
         need_cpu_ff <= req_data.vm_cpu;
         need_mem_ff <= req_data.vm_mem;
         tag_ff      <= req_data.vm_tag;
      end
      if (finish_fire) begin
         rsp_ff.placed      <= last_best.found;
         rsp_ff.chosen_host <= last_best.found ?
                               rfbf_pkg::HIDX_W'(last_best.index) : '0;
         rsp_ff.result_tag  <= tag_ff;
      end
   end

   // row of host cells
   assign step_chain[0] = start_ff;
   assign best_chain[0] = '0;

   for (genvar i = 0; i < rfbf_pkg::HOSTS; i++) begin : g_cell
      rfbf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (rfbf_pkg::IDX_W'(i)),
         .ctl        (ctl),
         .step_in    (step_chain[i]),
         .best_in    (best_chain[i]),
         .step_out   (step_chain[i+1]),
         .best_out   (best_chain[i+1]),
         .active_out (active_vec[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // search token is never in two cells at once
   a_token_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(step_chain))
      else $error("more than one search token in the cell row");

   // a new result only comes out of the finish step
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == rfbf_pkg::ST_FINISH)
      else $error("result raised outside the finish step");

   // the chosen host must be an active host
   a_chosen_active: assert property (@(posedge clock) disable iff (reset)
      (finish_fire && last_best.found) |-> active_vec[last_best.index])
      else $error("chosen host is not active");

   // no token while finishing
   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rfbf_pkg::ST_FINISH) |-> (step_chain == '0))
      else $error("search token present after the scan ended");

   // not placed reports host zero
   a_unplaced_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.placed) |-> (rsp_ff.chosen_host == '0))
      else $error("unplaced result carries a host index");

endmodule

// ----- design/rfbf_cell.sv -----
// one host cell: holds one table entry and passes the running best candidate on
`timescale 1ns / 1ps
module rfbf_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [rfbf_pkg::IDX_W-1:0] cell_index,
   input  rfbf_pkg::cell_ctl_type   ctl,
   input  logic                     step_in,
   input  rfbf_pkg::best_type       best_in,
   output logic                     step_out,
   output rfbf_pkg::best_type       best_out,
   output logic                     active_out
);

   logic [rfbf_pkg::CPU_W-1:0]  cpu_ff;
   logic [rfbf_pkg::MEM_W-1:0]  mem_ff;
   logic [rfbf_pkg::RANK_W-1:0] rank_ff;
   logic                        active_ff;
   logic                        step_ff;
   rfbf_pkg::best_type          best_ff;
   rfbf_pkg::best_type          best_in_c;

   logic [rfbf_pkg::CPU_W:0]    diff;
   logic                        fits;
   logic                        better;
   logic                        hit;

   assign hit  = (ctl.index == cell_index);
   assign diff = {1'b0, cpu_ff} - {1'b0, ctl.cpu};
   assign fits = active_ff && !diff[rfbf_pkg::CPU_W] && (mem_ff >= ctl.mem);

   always_comb begin
      better = fits && (!best_in.found || (rank_ff < best_in.rank) ||
                        ((rank_ff == best_in.rank) &&
                         (diff[rfbf_pkg::CPU_W-1:0] < best_in.slack)));
      best_in_c = best_in;
      if (better) begin
         best_in_c.found = 1'b1;
         best_in_c.rank  = rank_ff;
         best_in_c.slack = diff[rfbf_pkg::CPU_W-1:0];
         best_in_c.index = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff   <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (ctl.load_en && hit) begin
            active_ff <= ctl.active;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_en && hit) begin
         cpu_ff  <= ctl.cpu;
         mem_ff  <= ctl.mem;
         rank_ff <= ctl.rank;
      end else if (ctl.deduct_en && hit) begin
         cpu_ff <= cpu_ff - ctl.cpu;
         mem_ff <= mem_ff - ctl.mem;
      end
      if (step_in) begin
         best_ff <= best_in_c;
      end
   end

   assign step_out   = step_ff;
   assign best_out   = best_ff;
   assign active_out = active_ff;

endmodule

// ----- dv/rfbf_placer_checker.sv -----
// checker that predicts and compares every placement result of the best-fit placer
`timescale 1ns / 1ps
module rfbf_placer_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  rfbf_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rfbf_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count
);
   import rfbf_pkg::*;

   logic [CPU_W-1:0]  cpu_left [HOSTS];
   logic [MEM_W-1:0]  mem_left [HOSTS];
   logic [RANK_W-1:0] rank_of  [HOSTS];
   logic              host_on  [HOSTS];
   rsp_type           placements_due [$];
   int                fails = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      rsp_type           want;
      logic              found;
      logic [RANK_W-1:0] lead_rank;
      logic [CPU_W-1:0]  lead_slack;
      logic [CPU_W-1:0]  slack;
      logic [RANK_W-1:0] rank;
      int                best;
      if (reset) begin
         placements_due.delete();
         for (int i = 0; i < HOSTS; i++) begin
            cpu_left[i] = '0;
            mem_left[i] = '0;
            rank_of[i]  = '0;
            host_on[i]  = 1'b0;
         end
      end else begin
         // result transfer
         if (rsp_valid && !rsp_stall) begin
            if (placements_due.size() == 0) begin
               fails++;
               if (fails <= 10) begin
                  $display("%0t: result with none pending: placed=%0d host=%0d tag=%h",
                           $time, rsp_data.placed, rsp_data.chosen_host,
                           rsp_data.result_tag);
               end
            end else begin
               want = placements_due.pop_front();
               if (rsp_data.placed !== want.placed ||
                   rsp_data.chosen_host !== want.chosen_host ||
                   rsp_data.result_tag !== want.result_tag) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("%0t: mismatch: expected placed=%0d host=%0d tag=%h,",
                              $time, want.placed, want.chosen_host, want.result_tag);
                     $display("   got placed=%0d host=%0d tag=%h",
                              rsp_data.placed, rsp_data.chosen_host,
                              rsp_data.result_tag);
                  end
               end
            end
         end
         // request transfer
         if (req_valid && !req_stall) begin
            if (req_data.cmd == CMD_LOAD) begin
               if (int'(req_data.host_index) < HOSTS) begin
                  rank = req_data.host_rank;
                  if (int'(rank) > DC_RANKS - 1) begin
                     rank = RANK_W'(DC_RANKS - 1);
                  end
                  cpu_left[req_data.host_index] = req_data.host_free_cpu;
                  mem_left[req_data.host_index] = req_data.host_free_mem;
                  rank_of[req_data.host_index]  = rank;
                  host_on[req_data.host_index]  = req_data.host_active;
               end
            end else begin
               found      = 1'b0;
               lead_rank  = '0;
               lead_slack = '0;
               best       = 0;
               for (int i = 0; i < HOSTS; i++) begin
                  if (host_on[i] && cpu_left[i] >= req_data.vm_cpu &&
                      mem_left[i] >= req_data.vm_mem) begin
                     slack = cpu_left[i] - req_data.vm_cpu;
                     if (!found || rank_of[i] < lead_rank ||
                         (rank_of[i] == lead_rank && slack < lead_slack)) begin
                        found      = 1'b1;
                        lead_rank  = rank_of[i];
                        lead_slack = slack;
                        best       = i;
                     end
                  end
               end
               want.placed     = found;
               want.chosen_host = found ? HIDX_W'(best) : '0;
               want.result_tag = req_data.vm_tag;
               if (found) begin
                  cpu_left[best] = cpu_left[best] - req_data.vm_cpu;
                  mem_left[best] = mem_left[best] - req_data.vm_mem;
               end
               placements_due = {placements_due, want};
            end
         end
      end
      pending_count <= placements_due.size();
      fail_count    <= fails;
   end

endmodule

// ----- dv/tb_rank_first_best_fit_placer_unit.sv -----
// testbench top that drives load and place transfers into the best-fit placer
`timescale 1ns / 1ps
module tb_rank_first_best_fit_placer_unit;
   import rfbf_pkg::*;

   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 160;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int   gap_max = 4;
   int   stall_max = 4;
   logic hold_rsp_req = 1'b0;
   int   fail_count;
   int   pending_count;

   always #6 clock = ~clock;

   rank_first_best_fit_placer_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rfbf_placer_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   function automatic req_type load_item(input logic [HIDX_W-1:0] idx,
                                         input logic [CPU_W-1:0]  cpu,
                                         input logic [MEM_W-1:0]  mem,
                                         input logic [RANK_W-1:0] rank,
                                         input logic              on);
      req_type it;
      it.cmd           = CMD_LOAD;
      it.host_index    = idx;
      it.host_free_cpu = cpu;
      it.host_free_mem = mem;
      it.host_rank     = rank;
      it.host_active   = on;
      it.vm_cpu        = $urandom();
      it.vm_mem        = MEM_W'($urandom());
      it.vm_tag        = TAG_W'($urandom());
      return it;
   endfunction

   function automatic req_type place_item(input logic [CPU_W-1:0] cpu,
                                          input logic [MEM_W-1:0] mem,
                                          input logic [TAG_W-1:0] tag);
      req_type it;
      it.cmd           = CMD_PLACE;
      it.host_index    = HIDX_W'($urandom());
      it.host_free_cpu = $urandom();
      it.host_free_mem = MEM_W'($urandom());
      it.host_rank     = RANK_W'($urandom());
      it.host_active   = 1'($urandom());
      it.vm_cpu        = cpu;
      it.vm_mem        = mem;
      it.vm_tag        = tag;
      return it;
   endfunction

   function automatic req_type random_item();
      logic [CPU_W-1:0] cpu;
      logic [MEM_W-1:0] mem;
      int               pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         cpu = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0040_0000);
         mem = ($urandom_range(0, 3) == 0) ? MEM_W'($urandom())
                                           : MEM_W'($urandom_range(0, 65536));
         return load_item(HIDX_W'($urandom()), cpu, mem, RANK_W'($urandom()),
                          $urandom_range(0, 7) != 0);
      end
      case ($urandom_range(0, 9))
         0: begin
            cpu = $urandom();
            mem = MEM_W'($urandom());
         end
         1: begin
            cpu = '0;
            mem = '0;
         end
         default: begin
            cpu = $urandom_range(0, 32'h0008_0000);
            mem = MEM_W'($urandom_range(0, 16384));
         end
      endcase
      return place_item(cpu, mem, TAG_W'($urandom()));
   endfunction

   task automatic send(input req_type it);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_all_placed();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // result side: random stall before each transfer, one long hold on request
   initial begin
      int wait_cycles;
      forever begin
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            wait_cycles  = HOLD_CYCLES;
         end else begin
            wait_cycles = $urandom_range(0, stall_max);
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      #10_000_000;
      $display("tb_rank_first_best_fit_placer_unit failed");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty table, extremes of demand and tag
      send(place_item('1, '1, 16'hFFFF));
      send(place_item('0, '0, 16'h0000));
      send(load_item(6'd0, '1, '1, 4'd15, 1'b1));
      send(load_item(6'd63, '0, '0, 4'd0, 1'b1));
      send(place_item('0, '0, 16'h0001));
      send(place_item('1, '1, 16'h0002));
      send(place_item(32'd1, '0, 16'h0003));
      // inactive host is skipped
      send(load_item(6'd5, 32'h00FF_0000, 24'h00_1000, 4'd0, 1'b0));
      send(place_item(32'h0000_0100, 24'd1, 16'h0004));
      // rank wins over slack
      send(load_item(6'd10, 32'h0000_1000, 24'd100, 4'd3, 1'b1));
      send(load_item(6'd11, 32'hFFFF_0000, 24'd100000, 4'd2, 1'b1));
      send(place_item(32'h0000_0100, 24'd50, 16'h0005));
      // smallest slack within a rank
      send(load_item(6'd20, 32'h0000_0500, 24'd1000, 4'd1, 1'b1));
      send(load_item(6'd21, 32'h0000_0300, 24'd1000, 4'd1, 1'b1));
      send(place_item(32'h0000_0200, 24'd10, 16'h0006));
      // full tie goes to the lower index
      send(load_item(6'd30, 32'h0000_0800, 24'd500, 4'd0, 1'b1));
      send(load_item(6'd31, 32'h0000_0800, 24'd500, 4'd0, 1'b1));
      send(place_item(32'h0000_0800, 24'd500, 16'h0007));
      send(place_item(32'h0000_0800, 24'd500, 16'h0008));
      // memory shortfall, then deactivation by reload
      send(load_item(6'd40, 32'h0001_0000, 24'd10, 4'd0, 1'b1));
      send(place_item(32'h0000_0100, 24'd11, 16'h0009));
      send(load_item(6'd11, 32'hFFFF_0000, 24'd100000, 4'd2, 1'b0));
      send(place_item(32'h0000_0100, 24'd11, 16'h000A));
      wait_all_placed();

      // fill the whole table before the random part
      for (int i = 0; i < HOSTS; i++) begin
         send(load_item(HIDX_W'(i), $urandom_range(0, 32'h0040_0000),
                        MEM_W'($urandom_range(0, 65536)), RANK_W'($urandom()), 1'b1));
      end

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               gap_max   = 4;
               stall_max = 4;
            end
            1: begin
               gap_max      = 0;
               stall_max    = 2;
               hold_rsp_req = 1'b1;
            end
            2: begin
               gap_max   = 0;
               stall_max = 0;
            end
            default: begin
               gap_max   = 4;
               stall_max = 0;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send(random_item());
         end
         wait_all_placed();
      end

      repeat (HOSTS + 16) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_rank_first_best_fit_placer_unit passed");
      end else begin
         $display("tb_rank_first_best_fit_placer_unit failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/rfbf_pkg.sv
design/rfbf_cell.sv
design/rank_first_best_fit_placer_unit.sv
dv/rfbf_placer_checker.sv
dv/tb_rank_first_best_fit_placer_unit.sv
